// File: hdl/cpmp_pkg.sv
// Shared types and constants for the credential put message parser.
// Holds phase codes, protocol byte values, status codes and the result record.
// No dependencies.
`default_nettype none

package cpmp_pkg;

   localparam int PHASE_W  = 4;
   localparam int STATUS_W = 3;

   // Parser phases.
   localparam logic [PHASE_W-1:0] PH_ACTION      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_FIELD       = 4'd1;
   localparam logic [PHASE_W-1:0] PH_NAMELEN     = 4'd2;
   localparam logic [PHASE_W-1:0] PH_NAME        = 4'd3;
   localparam logic [PHASE_W-1:0] PH_PASSLEN     = 4'd4;
   localparam logic [PHASE_W-1:0] PH_PASS        = 4'd5;
   localparam logic [PHASE_W-1:0] PH_DONE        = 4'd6;
   localparam logic [PHASE_W-1:0] PH_ERR_ACTION  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_ERR_FIELD   = 4'd8;
   localparam logic [PHASE_W-1:0] PH_ERR_NAMELEN = 4'd9;
   localparam logic [PHASE_W-1:0] PH_ERR_PASSLEN = 4'd10;

   // Protocol byte values.
   localparam logic [7:0] PUT_ACTION_CODE  = 8'h01;
   localparam logic [7:0] USERS_FIELD_CODE = 8'h00;

   // Status codes reported in a terminal phase.
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ACTION  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FIELD   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_NAMELEN = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_PASSLEN = 3'd4;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase;
      logic                finished;
      logic                failed;
      logic [STATUS_W-1:0] status_code;
      logic                store_valid;
      logic                store_is_password;
      logic [7:0]          store_index;
      logic [7:0]          store_byte;
      logic                field_complete;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/cpmp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module cpmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 255
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/cpmp_seq.sv
// Parser sequencer: phase register, byte counters and per-byte result logic.
// Depends on cpmp_pkg.
`default_nettype none

module cpmp_seq #(
   parameter int MAX_FIELD_BYTES = 255
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic [7:0]       data_byte,
   input  wire logic             restart,
   output cpmp_pkg::rsp_type     result
);

   import cpmp_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_FIELD_BYTES);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0]         expected_ff, expected_in;
   logic [7:0]         taken_ff, taken_in;

   logic [PHASE_W-1:0] cur_phase;
   logic [7:0]         cur_expected;
   logic [7:0]         cur_taken;
   logic               len_ok;
   logic [7:0]         taken_inc;

   // A restart rewinds to the action phase before the byte is looked at.
   always_comb begin
      cur_phase    = restart ? PH_ACTION : phase_ff;
      cur_expected = restart ? 8'd0 : expected_ff;
      cur_taken    = restart ? 8'd0 : taken_ff;
      len_ok       = (data_byte != 8'd0) && (data_byte <= MAX_LEN);
      taken_inc    = cur_taken + 8'd1;
   end

   always_comb begin
      phase_in                 = cur_phase;
      expected_in              = cur_expected;
      taken_in                 = cur_taken;
      result                   = '0;
      case (cur_phase)
         PH_ACTION: begin
            phase_in = (data_byte == PUT_ACTION_CODE) ? PH_FIELD : PH_ERR_ACTION;
         end
         PH_FIELD: begin
            phase_in = (data_byte == USERS_FIELD_CODE) ? PH_NAMELEN : PH_ERR_FIELD;
         end
         PH_NAMELEN, PH_PASSLEN: begin
            if (!len_ok) begin
               phase_in = (cur_phase == PH_PASSLEN) ? PH_ERR_PASSLEN : PH_ERR_NAMELEN;
            end else begin
               expected_in = data_byte;
               taken_in    = 8'd0;
               phase_in    = (cur_phase == PH_PASSLEN) ? PH_PASS : PH_NAME;
            end
         end
         PH_NAME, PH_PASS: begin
            result.store_valid       = 1'b1;
            result.store_is_password = (cur_phase == PH_PASS);
            result.store_index       = cur_taken;
            result.store_byte        = data_byte;
            taken_in                 = taken_inc;
            if (taken_inc >= cur_expected) begin
               result.field_complete = 1'b1;
               phase_in = (cur_phase == PH_PASS) ? PH_DONE : PH_PASSLEN;
            end
         end
         default: begin
            // Terminal and unused phases ignore the byte.
         end
      endcase

      result.phase = phase_in;
      case (phase_in)
         PH_DONE: begin
            result.finished = 1'b1;
         end
         PH_ERR_ACTION: begin
            result.finished    = 1'b1;
            result.failed      = 1'b1;
            result.status_code = ST_BAD_ACTION;
         end
         PH_ERR_FIELD: begin
            result.finished    = 1'b1;
            result.failed      = 1'b1;
            result.status_code = ST_BAD_FIELD;
         end
         PH_ERR_NAMELEN: begin
            result.finished    = 1'b1;
            result.failed      = 1'b1;
            result.status_code = ST_BAD_NAMELEN;
         end
         PH_ERR_PASSLEN: begin
            result.finished    = 1'b1;
            result.failed      = 1'b1;
            result.status_code = ST_BAD_PASSLEN;
         end
         default: begin
            result.status_code = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_ACTION;
         expected_ff <= 8'd0;
         taken_ff    <= 8'd0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         expected_ff <= expected_in;
         taken_ff    <= taken_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/credential_put_message_parser_top.sv
// Credential put message parser, top level.
// Depends on cpmp_pkg, cpmp_seq and cpmp_ram.
//
// One request carries one message byte (req_data_byte) and a restart flag that
// rewinds the parser to the action phase before the byte is taken. Every
// request yields exactly one response: the new phase, finished and failed
// flags, a status code and the name or password store write the byte caused.
// Name and password bytes are written into two synchronous RAMs of
// MAX_FIELD_BYTES entries each.
// The response is registered; it is valid in the cycle after acceptance.
// One request per cycle unless a held response stalls; the phase and counter
// registers update on acceptance; each byte needs one RAM write port access.
// A response register separates the two sides, so a new request is taken in
// the same cycle the held response is taken. While rsp_valid is high and
// rsp_ready is low, req_ready is low and the response holds.
// Reset returns the parser to the action phase with cleared counters and
// empties the response register; the stores are not cleared.
`default_nettype none

module credential_put_message_parser_top #(
   parameter int MAX_FIELD_BYTES = 255
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic                           req_restart,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [cpmp_pkg::PHASE_W-1:0]        rsp_phase,
   output logic                                rsp_finished,
   output logic                                rsp_failed,
   output logic [cpmp_pkg::STATUS_W-1:0]       rsp_status_code,
   output logic                                rsp_store_valid,
   output logic                                rsp_store_is_password,
   output logic [7:0]                          rsp_store_index,
   output logic [7:0]                          rsp_store_byte,
   output logic                                rsp_field_complete
);

   import cpmp_pkg::*;

   localparam int STORE_AW = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;

   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    accept;
   logic    name_we;
   logic    pass_we;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   cpmp_seq #(
      .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step_en   (accept),
      .data_byte (req_data_byte),
      .restart   (req_restart),
      .result    (result)
   );

   assign name_we = accept && result.store_valid && !result.store_is_password;
   assign pass_we = accept && result.store_valid && result.store_is_password;

   cpmp_ram #(
      .WIDTH(8),
      .DEPTH(MAX_FIELD_BYTES)
   ) u_name_store (
      .clock   (clock),
      .wr_en   (name_we),
      .wr_addr (result.store_index[STORE_AW-1:0]),
      .wr_data (result.store_byte),
      .rd_addr ('0),
      .rd_data ()
   );

   cpmp_ram #(
      .WIDTH(8),
      .DEPTH(MAX_FIELD_BYTES)
   ) u_pass_store (
      .clock   (clock),
      .wr_en   (pass_we),
      .wr_addr (result.store_index[STORE_AW-1:0]),
      .wr_data (result.store_byte),
      .rd_addr ('0),
      .rd_data ()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_phase             = rsp_ff.phase;
   assign rsp_finished          = rsp_ff.finished;
   assign rsp_failed            = rsp_ff.failed;
   assign rsp_status_code       = rsp_ff.status_code;
   assign rsp_store_valid       = rsp_ff.store_valid;
   assign rsp_store_is_password = rsp_ff.store_is_password;
   assign rsp_store_index       = rsp_ff.store_index;
   assign rsp_store_byte        = rsp_ff.store_byte;
   assign rsp_field_complete    = rsp_ff.field_complete;

endmodule

`default_nettype wire

// File: hdl/cpmp_checker.sv
// Port-level checker for the credential put message parser, with its bind.
// Depends on cpmp_pkg and credential_put_message_parser_top.
`default_nettype none

module cpmp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [cpmp_pkg::PHASE_W-1:0]   rsp_phase,
   input wire logic                           rsp_finished,
   input wire logic                           rsp_failed,
   input wire logic [cpmp_pkg::STATUS_W-1:0]  rsp_status_code,
   input wire logic                           rsp_store_valid,
   input wire logic                           rsp_store_is_password,
   input wire logic [7:0]                     rsp_store_index,
   input wire logic [7:0]                     rsp_store_byte,
   input wire logic                           rsp_field_complete
);

   import cpmp_pkg::*;

   // Every accepted request shows up as a response in the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_phase)
                                     && $stable(rsp_store_byte)))
      else $error("stalled response changed");

   a_finished_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_finished == (rsp_phase == PH_DONE
                                      || rsp_phase == PH_ERR_ACTION
                                      || rsp_phase == PH_ERR_FIELD
                                      || rsp_phase == PH_ERR_NAMELEN
                                      || rsp_phase == PH_ERR_PASSLEN)))
      else $error("finished flag disagrees with phase");

   a_failed_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_failed == (rsp_status_code != ST_OK))
                    && (!rsp_failed || rsp_finished))
      else $error("failed flag disagrees with status code");

   a_no_store_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_store_valid) |-> (rsp_store_index == 8'd0
                                           && rsp_store_byte == 8'd0
                                           && !rsp_store_is_password
                                           && !rsp_field_complete))
      else $error("store fields set without a store write");

endmodule

bind credential_put_message_parser_top cpmp_checker u_cpmp_checker (.*);

`default_nettype wire
